// ----- rtl/bounded_indexed_list_top_defines.svh -----
// Assertion macros used by the list top level.
// Each macro samples on clk_i and is held off while rst_ni is low.
`ifndef BOUNDED_INDEXED_LIST_TOP_DEFINES_SVH
`define BOUNDED_INDEXED_LIST_TOP_DEFINES_SVH

// Check a property while the block is out of reset.
`define BIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication while the block is out of reset.
`define BIL_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/bil_pkg.sv -----
package bil_pkg;

  localparam int DefaultCapacity = 64;
  localparam int DataW = 32;
  localparam int PosW = 8;
  localparam int FuncW = 4;
  localparam int StatW = 7;

  typedef enum logic [FuncW-1:0] {
    FnInsFront = 4'd0,
    FnInsBack  = 4'd1,
    FnInsAt    = 4'd2,
    FnRemFront = 4'd3,
    FnRemBack  = 4'd4,
    FnRemAt    = 4'd5,
    FnSearch   = 4'd6,
    FnSelect   = 4'd7,
    FnReplace  = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    CkHold,
    CkIns,
    CkRem,
    CkWrite
  } cell_kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StResp
  } state_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_kind_e         kind;
    logic [PosW-1:0]    pos;
    logic [DataW-1:0]   data;
  } cell_cmd_t;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [PosW-1:0]    position;
    logic signed [DataW-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [DataW-1:0] read_value;
    logic [StatW-1:0]   found_position;
    logic [StatW-1:0]   count;
    logic               is_empty;
    logic               is_full;
  } res_t;

endpackage

// ----- rtl/bounded_indexed_list_top.sv -----
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one value per cell, head at cell 0. A request is taken at a rising edge
// with start high and busy low. Its single result is shown on res_o with
// done_o high for exactly one cycle, once the execute state has passed into
// the result state, and cannot be held off. In the execute state (busy high)
// the whole cell row shifts, writes or compares in parallel. In the result
// state the result is shown while the search priority encoder over the match
// bits picks the first hit. A new request may be given during the result
// state, so the block takes the next request while the last result is shown.
// After reset the list is empty and usable at once; cell contents need no
// clearing since only cells below the count are ever read.
`include "bounded_indexed_list_top_defines.svh"

module bounded_indexed_list_top #(
  parameter int CAPACITY = bil_pkg::DefaultCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bil_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output bil_pkg::res_t res_o
);
  import bil_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > PosW) ? CW : PosW;

  // Control state.
  state_e        st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Request and result holding registers.
  req_t          req_q;
  res_t          res_q;
  logic          srch_q;
  logic [CAPACITY-1:0] match_q;

  // Cell row wiring.
  cell_cmd_t           cmd;
  logic [DataW-1:0]    cell_val [CAPACITY];
  logic [DataW-1:0]    cell_rd  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_qual;
  logic [DataW-1:0]    rd_or;

  // Operation decode.
  logic            exec;
  logic            accept;
  logic            ok;
  logic            full, empty;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic [CW-1:0]   cnt_m1;
  logic [IW-1:0]   last_idx, tail_idx, req_idx, idx;
  logic [CW-1:0]   found;

  //--------------------------------------------------------------------------
  // Sequencer: idle, execute on the cell row, present the result.
  //--------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (start) begin
          st_d = StExec;
        end
      end
      StExec: begin
        st_d = StResp;
      end
      StResp: begin
        // Take a back-to-back request while the result is shown.
        st_d = start ? StExec : StIdle;
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    done_o = 1'b0;
    exec   = 1'b0;
    case (st_q)
      StExec: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      StResp: begin
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  //--------------------------------------------------------------------------
  // Decode the held request into one broadcast cell command.
  //--------------------------------------------------------------------------
  assign full     = (cnt_q == CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign pos_ext  = CMPW'(req_q.position);
  assign cnt_ext  = CMPW'(cnt_q);
  assign cnt_m1   = cnt_q - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  // Append slot; only used when not full, so the count fits the index.
  assign tail_idx = cnt_q[IW-1:0];
  assign req_idx  = pos_ext[IW-1:0];

  always_comb begin
    ok    = 1'b0;
    idx   = '0;
    cnt_d = cnt_q;
    cmd.kind = CkHold;
    cmd.data = req_q.data_value;
    if (exec) begin
      case (req_q.func)
        FnInsFront: begin
          ok = !full;
          cmd.kind = CkIns;
        end
        FnInsBack: begin
          ok  = !full;
          idx = tail_idx;
          cmd.kind = CkIns;
        end
        FnInsAt: begin
          ok  = !full;
          // Clamp a position past the tail to an append.
          idx = (pos_ext > cnt_ext) ? tail_idx : req_idx;
          cmd.kind = CkIns;
        end
        FnRemFront: begin
          ok = !empty;
          cmd.kind = CkRem;
        end
        FnRemBack: begin
          ok  = !empty;
          idx = last_idx;
          cmd.kind = CkRem;
        end
        FnRemAt: begin
          ok  = !empty;
          idx = (pos_ext >= cnt_ext) ? last_idx : req_idx;
          cmd.kind = CkRem;
        end
        FnSearch: begin
          ok = 1'b1;
        end
        FnSelect: begin
          ok  = !empty;
          idx = (pos_ext >= cnt_ext) ? last_idx : req_idx;
        end
        FnReplace: begin
          ok  = (pos_ext < cnt_ext);
          idx = req_idx;
          cmd.kind = CkWrite;
        end
        default: begin
        end
      endcase
      // Drop the row update on a refused request.
      if (!ok) begin
        cmd.kind = CkHold;
      end
      case (cmd.kind)
        CkIns:   cnt_d = cnt_q + CW'(1);
        CkRem:   cnt_d = cnt_m1;
        default: cnt_d = cnt_q;
      endcase
    end
    cmd.pos = PosW'(idx);
  end

  //--------------------------------------------------------------------------
  // Cell row: each cell takes a neighbor's value or the command data as commanded.
  //--------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left_v, right_v;
    if (g == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    bil_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[g]),
      .match_o (cell_match[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // Only stored cells may answer a search; gather the selected cell's value.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_qual[i] = cell_match[i] && (CW'(i) < cnt_q);
      rd_or         = rd_or | cell_rd[i];
    end
  end

  //--------------------------------------------------------------------------
  // Capture the request and the execute-cycle results.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (exec) begin
      res_q.ok             <= ok;
      res_q.read_value     <= (ok && (req_q.func == FnSelect)) ? rd_or : '0;
      res_q.found_position <= '0;
      res_q.count          <= StatW'(cnt_d);
      res_q.is_empty       <= (cnt_d == '0);
      res_q.is_full        <= (cnt_d == CW'(CAPACITY));
      srch_q               <= (req_q.func == FnSearch);
      match_q              <= match_qual;
    end
  end

  // Search leaves the count unchanged, so a miss reports the current count.
  bil_prienc #(
    .N  (CAPACITY),
    .CW (CW)
  ) u_prienc (
    .match_i (match_q),
    .none_i  (cnt_q),
    .idx_o   (found)
  );

  always_comb begin
    res_o = res_q;
    res_o.found_position = srch_q ? StatW'(found) : '0;
  end

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  `BIL_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "count exceeds capacity")
  `BIL_ASSERT_IMP(a_acc_busy, accept, ##1 busy, "accepted request did not execute")
  `BIL_ASSERT_IMP(a_busy_done, busy, ##1 done_o, "execute cycle not followed by result")
  `BIL_ASSERT_IMP(a_done_free, done_o, !busy, "result shown while executing")
  `BIL_ASSERT_IMP(a_flags, done_o && res_o.is_full, !res_o.is_empty, "full and empty at once")

endmodule

// ----- rtl/bil_cell.sv -----
module bil_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk_i,
  input  bil_pkg::cell_cmd_t       cmd_i,
  input  logic [bil_pkg::DataW-1:0] left_i,
  input  logic [bil_pkg::DataW-1:0] right_i,
  output logic [bil_pkg::DataW-1:0] value_o,
  output logic                     match_o,
  output logic [bil_pkg::DataW-1:0] rd_o
);
  import bil_pkg::*;

  localparam logic [PosW-1:0] IdxP = PosW'(IDX);

  logic [DataW-1:0] value_q, value_d;

  // Shift toward the tail on insert, toward the head on remove; write in place on replace.
  always_comb begin
    value_d = value_q;
    case (cmd_i.kind)
      CkIns: begin
        if (IdxP > cmd_i.pos) begin
          value_d = left_i;
        end else if (IdxP == cmd_i.pos) begin
          value_d = cmd_i.data;
        end
      end
      CkRem: begin
        if (IdxP >= cmd_i.pos) begin
          value_d = right_i;
        end
      end
      CkWrite: begin
        if (IdxP == cmd_i.pos) begin
          value_d = cmd_i.data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == cmd_i.data);
  assign rd_o    = (IdxP == cmd_i.pos) ? value_q : '0;

endmodule

// ----- rtl/bil_prienc.sv -----
module bil_prienc #(
  parameter int N  = 64,
  parameter int CW = 7
) (
  input  logic [N-1:0]  match_i,
  input  logic [CW-1:0] none_i,
  output logic [CW-1:0] idx_o
);

  // Lowest set bit wins; report none_i when nothing matched.
  always_comb begin
    idx_o = none_i;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        idx_o = CW'(i);
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import bil_pkg::*;

  localparam int CAP = DefaultCapacity;
  localparam int LIMIT = 200000;
  localparam int RANDOM_REQS = 2000;
  localparam int QUIET_TAIL = 300;
  localparam logic [FuncW-1:0] FnUnusedLo = 4'd9;
  localparam logic [FuncW-1:0] FnUnusedHi = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  // Shadow copy of the list contents and count, advanced at each accepted request.
  logic signed [DataW-1:0] shadow_vals [CAP];
  int shadow_cnt = 0;
  res_t pending_results[$];

  int n_errors = 0;
  int n_req = 0;
  int n_checked = 0;
  int n_rejected = 0;
  int peak_cnt = 0;
  int cycle_cnt = 0;
  bit gaps_on = 1'b1;
  bit drv_active = 1'b0;

  bounded_indexed_list_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Insert v at pos, clamping pos to the tail; refuse when full.
  function automatic bit list_insert(int pos, logic signed [DataW-1:0] v);
    if (shadow_cnt >= CAP) return 1'b0;
    if (pos > shadow_cnt) pos = shadow_cnt;
    for (int i = shadow_cnt; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
    shadow_vals[pos] = v;
    shadow_cnt++;
    return 1'b1;
  endfunction

  // Remove the element at pos, clamping pos to the tail; refuse when empty.
  function automatic bit list_remove(int pos);
    if (shadow_cnt == 0) return 1'b0;
    if (pos >= shadow_cnt) pos = shadow_cnt - 1;
    for (int i = pos; i + 1 < shadow_cnt; i++) shadow_vals[i] = shadow_vals[i+1];
    shadow_cnt--;
    return 1'b1;
  endfunction

  function automatic res_t predict_list_op(req_t rq);
    res_t r;
    int pos;
    bit hit;
    r = '0;
    pos = int'(rq.position);
    hit = 1'b0;
    case (rq.func)
      FnInsFront: r.ok = list_insert(0, rq.data_value);
      FnInsBack:  r.ok = list_insert(shadow_cnt, rq.data_value);
      FnInsAt:    r.ok = list_insert(pos, rq.data_value);
      FnRemFront: r.ok = list_remove(0);
      FnRemBack:  r.ok = list_remove(shadow_cnt);
      FnRemAt:    r.ok = list_remove(pos);
      FnSearch: begin
        // First match wins; a miss reports the count.
        r.ok = 1'b1;
        r.found_position = StatW'(shadow_cnt);
        for (int i = 0; i < shadow_cnt; i++) begin
          if (!hit && shadow_vals[i] == rq.data_value) begin
            r.found_position = StatW'(i);
            hit = 1'b1;
          end
        end
      end
      FnSelect: begin
        if (shadow_cnt != 0) begin
          r.ok = 1'b1;
          r.read_value = (pos < shadow_cnt) ? shadow_vals[pos] : shadow_vals[shadow_cnt-1];
        end
      end
      FnReplace: begin
        if (pos < shadow_cnt) begin
          shadow_vals[pos] = rq.data_value;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = StatW'(shadow_cnt);
    r.is_empty = (shadow_cnt == 0);
    r.is_full = (shadow_cnt == CAP);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Drop start if the driver holds it, then pause before the next request.
  task automatic pause_sender(int n);
    if (drv_active) begin
      start <= 1'b0;
      drv_active = 1'b0;
    end
    repeat (n) @(posedge clk_i);
  endtask

  // Present one request, wait until it is taken, and record its expected result.
  task automatic send_req(logic [FuncW-1:0] fn, int unsigned pos, logic signed [DataW-1:0] val);
    req_t rq;
    res_t want;
    rq.func = fn;
    rq.position = PosW'(pos);
    rq.data_value = val;
    req_i <= rq;
    start <= 1'b1;
    drv_active = 1'b1;
    do @(posedge clk_i); while (busy);
    want = predict_list_op(rq);
    pending_results.push_back(want);
    n_req++;
    if (!want.ok) n_rejected++;
    if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
    if (gaps_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 11));
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_results();
    pause_sender(0);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (res_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, res_o.ok);
          n_errors++;
        end
        if (res_o.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, res_o.read_value);
          n_errors++;
        end
        if (res_o.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, res_o.found_position);
          n_errors++;
        end
        if (res_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, res_o.count);
          n_errors++;
        end
        if (res_o.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, res_o.is_empty);
          n_errors++;
        end
        if (res_o.is_full !== want.is_full) begin
          $error("is_full: expected %0d, got %0d", want.is_full, res_o.is_full);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ends, clamped positions, duplicates and unused codes on a short list.
  task automatic test_edges();
    send_req(FnSelect, 0, 0);
    send_req(FnRemFront, 0, 0);
    send_req(FnRemBack, 0, 0);
    send_req(FnRemAt, 255, 0);
    send_req(FnReplace, 0, 1);
    send_req(FnSearch, 0, 5);
    send_req(FnUnusedHi, 255, -1);
    send_req(FnInsFront, 0, 32'sh8000_0000);
    send_req(FnInsBack, 0, 32'sh7fff_ffff);
    send_req(FnInsAt, 255, 7);
    send_req(FnInsAt, 1, 7);
    send_req(FnSearch, 0, 7);
    send_req(FnSearch, 0, 12345);
    send_req(FnSelect, 0, 0);
    send_req(FnSelect, 255, 0);
    send_req(FnReplace, 3, -1);
    send_req(FnReplace, 4, 9);
    send_req(FnReplace, 255, 9);
    send_req(FnRemAt, 255, 0);
    send_req(FnRemAt, 1, 0);
    send_req(FnRemBack, 0, 0);
    send_req(FnUnusedLo, 0, 0);
    send_req(FnRemFront, 0, 0);
    send_req(FnInsAt, 0, 0);
    send_req(FnSearch, 0, 0);
  endtask

  // Fill to capacity, poke every operation at the full boundary, then step back.
  task automatic test_full_list();
    while (shadow_cnt < CAP) send_req(FnInsBack, 0, pick_value());
    send_req(FnInsFront, 0, 1);
    send_req(FnInsBack, 0, 2);
    send_req(FnInsAt, 10, 3);
    send_req(FnUnusedHi, 0, 0);
    send_req(FnSelect, CAP - 1, 0);
    send_req(FnSelect, CAP, 0);
    send_req(FnReplace, CAP - 1, 32'sh1234_5678);
    send_req(FnSearch, 0, 32'sh1234_5678);
    send_req(FnReplace, CAP, 0);
    send_req(FnRemAt, CAP, 0);
    send_req(FnInsAt, 10, 4);
    send_req(FnRemFront, 0, 0);
    send_req(FnRemBack, 0, 0);
  endtask

  // Random walk through the list: segments that grow, shrink or stay balanced.
  task automatic test_random();
    int mode;
    int ins_pct;
    int rem_pct;
    int roll;
    int unsigned pos;
    logic [FuncW-1:0] fn;
    logic signed [DataW-1:0] val;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k % 100 == 0) begin
        mode = $urandom_range(0, 2);
        ins_pct = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
        rem_pct = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
        // Keep some segments free of gaps, and the whole tail of the run.
        gaps_on = (k < RANDOM_REQS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) fn = FuncW'($urandom_range(FnUnusedLo, FnUnusedHi));
      else if (roll < 3 + ins_pct) fn = FuncW'($urandom_range(FnInsFront, FnInsAt));
      else if (roll < 3 + ins_pct + rem_pct) fn = FuncW'($urandom_range(FnRemFront, FnRemAt));
      else fn = FuncW'($urandom_range(FnSearch, FnReplace));
      // Mostly positions near the live range, sometimes anywhere in the field.
      if ($urandom_range(0, 9) < 7) pos = $urandom_range(0, shadow_cnt + 1);
      else pos = $urandom_range(0, 255);
      val = pick_value();
      if (fn == FnSearch && shadow_cnt != 0 && $urandom_range(0, 9) < 6)
        val = shadow_vals[$urandom_range(0, shadow_cnt - 1)];
      send_req(fn, pos, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edges();
    drain_results();
    test_full_list();
    drain_results();
    test_random();
    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d list requests, %0d results checked, %0d refused.",
             n_req, n_checked, n_rejected);
    $display("List depth reached %0d of %0d across grow, shrink and balanced phases.",
             peak_cnt, CAP);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bil_pkg.sv
rtl/bil_cell.sv
rtl/bil_prienc.sv
rtl/bounded_indexed_list_top.sv
dv/tb.sv
